// ===== rtl/wsdb_pkg.sv =====
// Shared types and codes for the work-stealing deque bank.
// No dependencies; used by every module under rtl/ except wsdb_ram.
package wsdb_pkg;

    // Operation codes
    localparam logic [1:0] OP_PUSH  = 2'd0;
    localparam logic [1:0] OP_POP   = 2'd1;
    localparam logic [1:0] OP_STEAL = 2'd2;
    localparam logic [1:0] OP_NONE  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Widths fixed by the request fields
    localparam int unsigned IDX_W  = 4;
    localparam int unsigned TASK_W = 32;
    localparam int unsigned LVL_W  = 7;

    // Command queue between front and back
    localparam int unsigned CMDQ_DEPTH = 2;
    localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  requester;
        logic [IDX_W-1:0]  victim;
        logic [TASK_W-1:0] task_in;
    } req_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [TASK_W-1:0] task_out;
        logic              throttle;
    } rsp_t;

    // Classified command: target deque already reduced to a valid index
    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  queue;
        logic              self_steal;
        logic [TASK_W-1:0] task_in;
    } cmd_t;

endpackage

// ===== rtl/wsdb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wsdb_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/wsdb_front.sv =====
// Front end: accepts requests and classifies them into queue commands.
// Depends on wsdb_pkg.
module wsdb_front #(
    parameter int unsigned NUM_QUEUES = 16
) (
    input  logic              start,
    input  logic              full,
    input  wsdb_pkg::req_t    req,
    output logic              push,
    output wsdb_pkg::cmd_t    cmd
);

    logic [wsdb_pkg::IDX_W-1:0] req_q;
    logic [wsdb_pkg::IDX_W-1:0] vic_q;

    // Reduce worker indexes to the deques that exist
    always_comb
    begin
        req_q = '0;
        vic_q = '0;
        for (int i = 0; i < (1 << wsdb_pkg::IDX_W); i++)
        begin
            if (req.requester == wsdb_pkg::IDX_W'(i))
            begin
                req_q = wsdb_pkg::IDX_W'(i % NUM_QUEUES);
            end
            if (req.victim == wsdb_pkg::IDX_W'(i))
            begin
                vic_q = wsdb_pkg::IDX_W'(i % NUM_QUEUES);
            end
        end
    end

    // Pick the target deque and flag a steal from the own deque
    always_comb
    begin
        cmd.op         = req.op;
        cmd.task_in    = req.task_in;
        cmd.self_steal = (req_q == vic_q);
        cmd.queue      = (req.op == wsdb_pkg::OP_STEAL) ? vic_q : req_q;
    end

    assign push = start && !full;

endmodule

// ===== rtl/wsdb_cmdq.sv =====
// Short command queue between the front end and the back end.
// Depends on wsdb_pkg.
module wsdb_cmdq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  wsdb_pkg::cmd_t    push_data,
    input  logic              pop,
    output wsdb_pkg::cmd_t    pop_data,
    output logic              full,
    output logic              empty
);

    localparam int unsigned AW = (wsdb_pkg::CMDQ_AW > 0) ? wsdb_pkg::CMDQ_AW : 1;

    wsdb_pkg::cmd_t               entry_reg [wsdb_pkg::CMDQ_DEPTH];
    logic [AW-1:0]                wr_ptr_reg;
    logic [AW-1:0]                wr_ptr_next;
    logic [AW-1:0]                rd_ptr_reg;
    logic [AW-1:0]                rd_ptr_next;
    logic [AW:0]                  count_reg;
    logic [AW:0]                  count_next;

    assign full     = (count_reg == (AW+1)'(wsdb_pkg::CMDQ_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(wsdb_pkg::CMDQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(wsdb_pkg::CMDQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && !empty))
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!(push && !full) && (pop && !empty))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push && !full)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/wsdb_back.sv =====
// Back end: pointer lookup, slot access and result formation per command.
// Depends on wsdb_pkg and wsdb_ram.
module wsdb_back #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_QUEUES  = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         empty,
    input  wsdb_pkg::cmd_t               cmd,
    input  logic [wsdb_pkg::LVL_W-1:0]   throttle_level,
    output logic                         pop,
    output logic                         done,
    output wsdb_pkg::rsp_t               rsp
);

    localparam int unsigned PW  = $clog2(QUEUE_DEPTH) + 1;
    localparam int unsigned SW  = $clog2(QUEUE_DEPTH);
    localparam int unsigned QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int unsigned AW  = $clog2(NUM_QUEUES * QUEUE_DEPTH);
    localparam int unsigned CW  = (PW > wsdb_pkg::LVL_W) ? PW : wsdb_pkg::LVL_W;
    localparam logic [PW-1:0] PTR_LAST = PW'(2 * QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PTR,
        S_SLOT
    } state_t;

    state_t                        state_reg;
    wsdb_pkg::cmd_t                cmd_reg;
    logic [1:0]                    status_reg;
    logic                          throttle_reg;
    logic                          done_reg;
    wsdb_pkg::rsp_t                rsp_reg;
    logic [NUM_QUEUES-1:0]         ptr_valid_reg;
    logic                          ptr_hit_reg;

    logic [QAW-1:0]                ptr_raddr;
    logic [QAW-1:0]                ptr_waddr;
    logic [2*PW-1:0]               ptr_rdata;
    logic [2*PW-1:0]               ptr_wdata;
    logic                          ptr_we;
    logic [AW-1:0]                 slot_raddr;
    logic [AW-1:0]                 slot_waddr;
    logic                          slot_we;
    logic [wsdb_pkg::TASK_W-1:0]   slot_rdata;

    logic [PW-1:0]                 top_w;
    logic [PW-1:0]                 bot_w;
    logic [PW:0]                   diff_w;
    logic [PW-1:0]                 occ_w;
    logic [PW-1:0]                 top_new;
    logic [PW-1:0]                 bot_new;
    logic [PW-1:0]                 slot_ptr;
    logic [1:0]                    status_w;
    logic                          throttle_w;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
        ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    function automatic logic [SW-1:0] ptr_slot(input logic [PW-1:0] p);
        logic [PW-1:0] s;
        s = (p >= PW'(QUEUE_DEPTH)) ? p - PW'(QUEUE_DEPTH) : p;
        ptr_slot = s[SW-1:0];
    endfunction

    // Pointer pair store, {top, bottom} per deque
    wsdb_ram #(
        .WIDTH (2 * PW),
        .DEPTH (NUM_QUEUES)
    ) u_ptr_ram (
        .clk   (clk),
        .we    (ptr_we),
        .waddr (ptr_waddr),
        .wdata (ptr_wdata),
        .raddr (ptr_raddr),
        .rdata (ptr_rdata)
    );

    // Task slot store
    wsdb_ram #(
        .WIDTH (wsdb_pkg::TASK_W),
        .DEPTH (NUM_QUEUES * QUEUE_DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (cmd_reg.task_in),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    assign pop       = (state_reg == S_IDLE) && !empty;
    assign ptr_raddr = QAW'(cmd.queue);
    assign ptr_waddr = QAW'(cmd_reg.queue);
    assign done      = done_reg;
    assign rsp       = rsp_reg;

    // Decode pointers and occupancy of the target deque
    always_comb
    begin
        top_w  = ptr_hit_reg ? ptr_rdata[2*PW-1:PW] : '0;
        bot_w  = ptr_hit_reg ? ptr_rdata[PW-1:0]    : '0;
        diff_w = {1'b0, bot_w} - {1'b0, top_w};
        occ_w  = diff_w[PW] ? PW'(diff_w + (PW+1)'(2 * QUEUE_DEPTH)) : diff_w[PW-1:0];
    end

    // Carry out the command on the looked-up pointers
    always_comb
    begin
        top_new    = top_w;
        bot_new    = bot_w;
        slot_ptr   = bot_w;
        status_w   = wsdb_pkg::ST_DONE;
        throttle_w = 1'b0;
        ptr_we     = 1'b0;
        slot_we    = 1'b0;
        case (cmd_reg.op)
            wsdb_pkg::OP_PUSH:
            begin
                if (occ_w >= PW'(QUEUE_DEPTH))
                begin
                    status_w = wsdb_pkg::ST_FULL;
                end
                else
                begin
                    slot_we = (state_reg == S_PTR);
                    ptr_we  = (state_reg == S_PTR);
                    bot_new = ptr_inc(bot_w);
                end
            end
            wsdb_pkg::OP_POP:
            begin
                throttle_w = (occ_w != '0) &&
                             (CW'(occ_w) - 1'b1 > CW'(throttle_level));
                slot_ptr   = ptr_dec(bot_w);
                if (occ_w == '0)
                begin
                    status_w = wsdb_pkg::ST_EMPTY;
                end
                else
                begin
                    ptr_we = (state_reg == S_PTR);
                    if (occ_w == PW'(1))
                    begin
                        top_new = ptr_inc(top_w);
                        bot_new = ptr_inc(top_w);
                    end
                    else
                    begin
                        bot_new = ptr_dec(bot_w);
                    end
                end
            end
            wsdb_pkg::OP_STEAL:
            begin
                throttle_w = cmd_reg.self_steal && (CW'(occ_w) > CW'(throttle_level));
                slot_ptr   = top_w;
                if (occ_w == '0)
                begin
                    status_w = wsdb_pkg::ST_EMPTY;
                end
                else
                begin
                    ptr_we  = (state_reg == S_PTR);
                    top_new = ptr_inc(top_w);
                end
            end
            default:
            begin
                status_w = wsdb_pkg::ST_DONE;
            end
        endcase
        ptr_wdata  = {top_new, bot_new};
        slot_raddr = AW'(cmd_reg.queue) * AW'(QUEUE_DEPTH) + AW'(ptr_slot(slot_ptr));
        slot_waddr = slot_raddr;
    end

    // Sequence one command: pointer read, update and slot access, result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cmd_reg      <= '0;
            status_reg   <= wsdb_pkg::ST_DONE;
            throttle_reg <= 1'b0;
            done_reg     <= 1'b0;
            rsp_reg      <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (!empty)
                    begin
                        cmd_reg   <= cmd;
                        state_reg <= S_PTR;
                    end
                end
                S_PTR:
                begin
                    status_reg   <= status_w;
                    throttle_reg <= throttle_w;
                    state_reg    <= S_SLOT;
                end
                S_SLOT:
                begin
                    done_reg         <= 1'b1;
                    rsp_reg.status   <= status_reg;
                    rsp_reg.throttle <= throttle_reg;
                    rsp_reg.task_out <= ((status_reg == wsdb_pkg::ST_DONE) &&
                                         ((cmd_reg.op == wsdb_pkg::OP_POP) ||
                                          (cmd_reg.op == wsdb_pkg::OP_STEAL)))
                                        ? slot_rdata : '0;
                    state_reg        <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Track which pointer entries hold written values; others read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_valid_reg <= '0;
            ptr_hit_reg   <= 1'b0;
        end
        else
        begin
            ptr_hit_reg <= ptr_valid_reg[ptr_raddr];
            if (ptr_we)
            begin
                ptr_valid_reg[ptr_waddr] <= 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_slot_gives_done : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SLOT |=> done_reg)
        else $error("result strobe missing after slot access");

    a_no_task_on_fail : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status != wsdb_pkg::ST_DONE |-> rsp_reg.task_out == '0)
        else $error("task handle returned with failing status");

    a_push_result : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && cmd_reg.op == wsdb_pkg::OP_PUSH |->
            rsp_reg.task_out == '0 && !rsp_reg.throttle)
        else $error("push returned a handle or throttle");

    a_full_only_push : assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == wsdb_pkg::ST_FULL |-> cmd_reg.op == wsdb_pkg::OP_PUSH)
        else $error("full status on a non-push command");
`endif

endmodule

// ===== rtl/work_stealing_deque_bank.sv =====
// Top level of the work-stealing deque bank: config register, front end,
// command queue and back end. Depends on wsdb_pkg, wsdb_front, wsdb_cmdq, wsdb_back.
//
//  channel    handshake           payload
//  --------   -----------------   ----------------------------------
//  request    start / busy        req  (op, requester, victim, task_in)
//  result     done (strobe)       rsp  (status, task_out, throttle)
//  config     cfg_we              cfg_wdata (throttle level)
//
// The back end takes each transaction through three steps: pointer RAM read,
// pointer update with slot RAM access, result register. It finishes one
// transaction before it takes the next from the command queue. Up to two
// accepted transactions wait in the command queue; busy is high while it is
// full. Reset clears the pointer valid bits at once, so the bank accepts
// requests as soon as reset is released.
module work_stealing_deque_bank #(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_QUEUES  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  wsdb_pkg::req_t              req,
    output logic                        done,
    output wsdb_pkg::rsp_t              rsp,
    input  logic                        cfg_we,
    input  logic [wsdb_pkg::LVL_W-1:0]  cfg_wdata
);

    localparam logic [wsdb_pkg::LVL_W-1:0] THROTTLE_RESET =
        wsdb_pkg::LVL_W'((QUEUE_DEPTH * 7 / 10) % (1 << wsdb_pkg::LVL_W));

    logic [wsdb_pkg::LVL_W-1:0]  throttle_level_reg;
    logic                        q_push;
    logic                        q_pop;
    logic                        q_full;
    logic                        q_empty;
    wsdb_pkg::cmd_t              q_in;
    wsdb_pkg::cmd_t              q_out;

    assign busy = q_full;

    // Hold the throttle level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            throttle_level_reg <= THROTTLE_RESET;
        end
        else if (cfg_we)
        begin
            throttle_level_reg <= cfg_wdata;
        end
    end

    wsdb_front #(
        .NUM_QUEUES (NUM_QUEUES)
    ) u_front (
        .start (start),
        .full  (q_full),
        .req   (req),
        .push  (q_push),
        .cmd   (q_in)
    );

    wsdb_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    wsdb_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .empty          (q_empty),
        .cmd            (q_out),
        .throttle_level (throttle_level_reg),
        .pop            (q_pop),
        .done           (done),
        .rsp            (rsp)
    );

endmodule

// ===== dv/wsdb_checker.sv =====
// Transaction checker for the work-stealing deque bank: predicts each request,
// compares every result strobe field by field. Depends on wsdb_pkg.
module wsdb_checker
    import wsdb_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 64,
    parameter int unsigned NUM_QUEUES  = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  req_t              req,
    input  logic              done,
    input  rsp_t              rsp,
    input  logic              cfg_we,
    input  logic [LVL_W-1:0]  cfg_wdata,
    output int                fail_count,
    output int                pending
);

    localparam int unsigned PTR_W  = $clog2(2 * QUEUE_DEPTH);
    localparam int unsigned SLOT_W = $clog2(QUEUE_DEPTH);
    localparam logic [LVL_W-1:0] LEVEL_AT_RESET = LVL_W'(QUEUE_DEPTH * 7 / 10);

    // Shadow copy of the bank
    logic [TASK_W-1:0] slots   [NUM_QUEUES][QUEUE_DEPTH];
    logic [PTR_W-1:0]  top_ptr [NUM_QUEUES];
    logic [PTR_W-1:0]  bot_ptr [NUM_QUEUES];
    logic [LVL_W-1:0]  level;

    rsp_t outstanding_rsp [$];
    rsp_t oldest;

    initial fail_count = 0;

    task automatic report_mismatch(string what, logic [TASK_W-1:0] got,
                                   logic [TASK_W-1:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
        fail_count++;
    endtask

    // Apply one transaction to the shadow bank and return its result
    function automatic rsp_t apply_deque_op(req_t r);
        rsp_t             res;
        logic [IDX_W-1:0] q;
        logic [IDX_W-1:0] who;
        logic [PTR_W-1:0] cnt;
        logic [PTR_W-1:0] nb;
        res = '0;
        who = IDX_W'(r.requester % NUM_QUEUES);
        case (r.op)
            OP_PUSH:
            begin
                q   = who;
                cnt = bot_ptr[q] - top_ptr[q];
                if (cnt >= QUEUE_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    slots[q][bot_ptr[q][SLOT_W-1:0]] = r.task_in;
                    bot_ptr[q] = bot_ptr[q] + 1'b1;
                end
            end
            OP_POP:
            begin
                q   = who;
                cnt = bot_ptr[q] - top_ptr[q];
                res.throttle = (cnt != 0) && ((cnt - 1) > level);
                if (cnt == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    nb = bot_ptr[q] - 1'b1;
                    res.task_out = slots[q][nb[SLOT_W-1:0]];
                    // last task: both pointers settle one past the old top
                    if (cnt == 1)
                    begin
                        top_ptr[q] = top_ptr[q] + 1'b1;
                        bot_ptr[q] = top_ptr[q];
                    end
                    else
                        bot_ptr[q] = nb;
                end
            end
            OP_STEAL:
            begin
                q   = IDX_W'(r.victim % NUM_QUEUES);
                cnt = bot_ptr[q] - top_ptr[q];
                res.throttle = (who == q) && (cnt > level);
                if (cnt == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.task_out = slots[q][top_ptr[q][SLOT_W-1:0]];
                    top_ptr[q] = top_ptr[q] + 1'b1;
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                top_ptr[i] = '0;
                bot_ptr[i] = '0;
            end
            level = LEVEL_AT_RESET;
            outstanding_rsp.delete();
            pending = 0;
        end
        else
        begin
            // compare the result leaving the bank with the oldest prediction
            if (done)
            begin
                if (outstanding_rsp.size() == 0)
                    report_mismatch("unexpected result", rsp.task_out, '0);
                else
                begin
                    oldest = outstanding_rsp.pop_front();
                    if (rsp.status !== oldest.status)
                        report_mismatch("status", TASK_W'(rsp.status),
                                        TASK_W'(oldest.status));
                    if (rsp.task_out !== oldest.task_out)
                        report_mismatch("task_out", rsp.task_out, oldest.task_out);
                    if (rsp.throttle !== oldest.throttle)
                        report_mismatch("throttle", TASK_W'(rsp.throttle),
                                        TASK_W'(oldest.throttle));
                end
            end
            // predict each accepted request
            if (start && !busy)
                outstanding_rsp.push_back(apply_deque_op(req));
            if (cfg_we)
                level = cfg_wdata;
            pending = outstanding_rsp.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// Top of the deque bank testbench: clock, reset, request stimulus and verdict.
// Depends on wsdb_pkg, work_stealing_deque_bank and wsdb_checker.
module testbench;
    import wsdb_pkg::*;

    localparam int unsigned QUEUE_DEPTH = 64;
    localparam int unsigned NUM_QUEUES  = 16;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 470;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    req_t             req;
    logic             done;
    rsp_t             rsp;
    logic             cfg_we;
    logic [LVL_W-1:0] cfg_wdata;

    int               fail_count;
    int               pending;
    int               cycle_count = 0;
    int               idle_pct;
    int               push_pct;
    logic [IDX_W-1:0] hot_a;
    logic [IDX_W-1:0] hot_b;

    work_stealing_deque_bank #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    wsdb_checker #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_QUEUES  (NUM_QUEUES)
    ) bank_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic req_t make_req(logic [1:0] op, logic [IDX_W-1:0] who,
                                      logic [IDX_W-1:0] vic, logic [TASK_W-1:0] handle);
        req_t r;
        r.op        = op;
        r.requester = who;
        r.victim    = vic;
        r.task_in   = handle;
        return r;
    endfunction

    // Mostly traffic on two hot deques so they fill and drain; some anywhere
    function automatic req_t random_request();
        req_t             r;
        int               roll;
        logic [IDX_W-1:0] q;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 9) < 8)
            q = $urandom_range(0, 1) ? hot_a : hot_b;
        else
            q = IDX_W'($urandom_range(0, NUM_QUEUES - 1));
        r.requester = q;
        r.victim    = IDX_W'($urandom);
        r.task_in   = $urandom;
        if (roll < 2)
            r.op = OP_NONE;
        else if (roll < 2 + push_pct)
            r.op = OP_PUSH;
        else if ($urandom_range(0, 1))
            r.op = OP_POP;
        else
        begin
            r.op     = OP_STEAL;
            r.victim = q;
            if ($urandom_range(0, 2) != 0)
                r.requester = IDX_W'($urandom);
        end
        return r;
    endfunction

    // Hold start with the request until a clock edge finds busy low
    task automatic issue(req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(0, 99) < idle_pct)
            gap++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    // Drain outstanding transactions, then write the throttle level
    task automatic set_throttle_level(logic [LVL_W-1:0] value);
        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int phase_level [4];
        int phase_idle  [4];
        int phase_push  [4];
        phase_level = '{0, 64, 127, 0};
        phase_level[3] = $urandom_range(1, 63);
        phase_idle  = '{25, 55, 0, 0};
        phase_push  = '{72, 30, 55, 50};

        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        idle_pct  = 25;
        push_pct  = 50;
        hot_a     = '0;
        hot_b     = '1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty deques, unused op, extreme handles and indexes,
        // last-task pop, self steal, at the reset throttle level
        issue(make_req(OP_POP,   4'd0,  4'd0,  32'h0000_0000));
        issue(make_req(OP_STEAL, 4'd0,  4'd15, 32'h0000_0000));
        issue(make_req(OP_NONE,  4'd15, 4'd15, 32'hFFFF_FFFF));
        issue(make_req(OP_PUSH,  4'd0,  4'd15, 32'hFFFF_FFFF));
        issue(make_req(OP_PUSH,  4'd0,  4'd0,  32'h0000_0000));
        issue(make_req(OP_PUSH,  4'd15, 4'd0,  32'hA5A5_A5A5));
        issue(make_req(OP_STEAL, 4'd3,  4'd0,  32'h0000_0000));
        issue(make_req(OP_POP,   4'd0,  4'd7,  32'h0000_0000));
        issue(make_req(OP_POP,   4'd0,  4'd0,  32'h0000_0000));
        issue(make_req(OP_PUSH,  4'd0,  4'd0,  32'h1234_5678));
        issue(make_req(OP_STEAL, 4'd0,  4'd0,  32'h0000_0000));
        issue(make_req(OP_PUSH,  4'd0,  4'd0,  32'h5A5A_5A5A));
        issue(make_req(OP_POP,   4'd0,  4'd0,  32'h0000_0000));
        issue(make_req(OP_STEAL, 4'd15, 4'd15, 32'h0000_0000));
        issue(make_req(OP_POP,   4'd15, 4'd0,  32'h0000_0000));
        issue(make_req(OP_NONE,  4'd0,  4'd0,  32'h0000_0000));

        // Random phases at several throttle levels and idle mixes
        for (int p = 0; p < 4; p++)
        begin
            set_throttle_level(LVL_W'(phase_level[p]));
            idle_pct = phase_idle[p];
            push_pct = phase_push[p];
            hot_a    = IDX_W'($urandom);
            hot_b    = hot_a ^ IDX_W'($urandom_range(1, NUM_QUEUES - 1));
            repeat (ITEMS_PER_PHASE) issue(random_request());
        end

        start <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== work_stealing_deque_bank.f =====
rtl/wsdb_pkg.sv
rtl/wsdb_ram.sv
rtl/wsdb_front.sv
rtl/wsdb_cmdq.sv
rtl/wsdb_back.sv
rtl/work_stealing_deque_bank.sv
dv/wsdb_checker.sv
dv/testbench.sv
